// ----- sv/pzba_pkg.sv -----
// ----------------------------------------------------------------------------
// pzba_pkg: shared types and constants for the proximity zone blink alert
// Field widths, register indexes, zone codes, sequencer states and the
// fixed arithmetic constants used by the rate path.
// ----------------------------------------------------------------------------
package pzba_pkg;

	// field and register widths
	localparam int DIST_W    = 16;
	localparam int THR_W     = 12;
	localparam int BASE_W    = 8;
	localparam int SLOPE_W   = 4;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	// rate path: closer_cm = (x * RECIP_10) >> RECIP_SH, exact for x < 4096
	localparam int RECIP_10  = 6554;
	localparam int RECIP_W   = 13;
	localparam int RECIP_SH  = 16;
	localparam int CLOSER_W  = 9;
	localparam int BPM_W     = 13;

	// half period numerator in ms and quotient width
	localparam int PERIOD_MS = 30000;
	localparam int QUOT_W    = 15;

	// digit width of the serial time subtractor
	localparam int DIGIT_W   = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALERT  = 2'd0,
		CFG_DANGER = 2'd1,
		CFG_BASE   = 2'd2,
		CFG_SLOPE  = 2'd3
	} cfg_idx_t;

	// result zone codes
	typedef enum logic [1:0] {
		ZONE_SAFE   = 2'd0,
		ZONE_WARN   = 2'd1,
		ZONE_DANGER = 2'd2
	} zone_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BPM,
		ST_RUN,
		ST_FIN
	} state_t;

	// control from the sequencer to a serial unit
	typedef struct packed {
		logic load;
		logic step;
	} ctl_t;

endpackage

// ----- sv/pzba_serial_sub.sv -----
// ----------------------------------------------------------------------------
// pzba_serial_sub: digit-serial subtractor for elapsed time
// Computes a - b modulo 2^TIME_WIDTH, DIGIT_W bits per step, LSB first.
// ----------------------------------------------------------------------------
module pzba_serial_sub #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pzba_pkg::ctl_t        ctl,
	input  logic [TIME_WIDTH-1:0] a,
	input  logic [TIME_WIDTH-1:0] b,
	output logic [TIME_WIDTH-1:0] diff
);
	import pzba_pkg::*;

	localparam int ND  = (TIME_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int NDW = ND * DIGIT_W;

	logic [NDW-1:0]     a_sr_q, b_sr_q, d_sr_q;
	logic               borrow_q;
	logic [DIGIT_W:0]   dig;

	// one digit of a - b - borrow; top bit is the outgoing borrow
	assign dig = {1'b0, a_sr_q[DIGIT_W-1:0]} - {1'b0, b_sr_q[DIGIT_W-1:0]}
		- {{DIGIT_W{1'b0}}, borrow_q};

	// borrow chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			borrow_q <= 1'b0;
		end else if (ctl.load) begin
			borrow_q <= 1'b0;
		end else if (ctl.step) begin
			borrow_q <= dig[DIGIT_W];
		end
	end

	// operand and result shift registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_sr_q <= NDW'(a);
			b_sr_q <= NDW'(b);
		end else if (ctl.step) begin
			a_sr_q <= a_sr_q >> DIGIT_W;
			b_sr_q <= b_sr_q >> DIGIT_W;
			d_sr_q <= {dig[DIGIT_W-1:0], d_sr_q[NDW-1:DIGIT_W]};
		end
	end

	assign diff = d_sr_q[TIME_WIDTH-1:0];

endmodule

// ----- sv/pzba_div.sv -----
// ----------------------------------------------------------------------------
// pzba_div: bit-serial restoring divider
// Produces floor(PERIOD_MS / divisor), one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module pzba_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pzba_pkg::ctl_t               ctl,
	input  logic [pzba_pkg::BPM_W-1:0]   divisor,
	output logic [pzba_pkg::QUOT_W-1:0]  quot
);
	import pzba_pkg::*;

	logic [BPM_W-1:0]  div_q;
	logic [BPM_W:0]    rem_q;
	logic [QUOT_W-1:0] dq_q;
	logic [BPM_W:0]    rem_sh;
	logic              fits;

	// shift in next dividend bit and trial subtract
	assign rem_sh = {rem_q[BPM_W-1:0], dq_q[QUOT_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	// divisor hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
		end else if (ctl.load) begin
			div_q <= divisor;
		end
	end

	// remainder and dividend/quotient register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			dq_q  <= QUOT_W'(PERIOD_MS);
		end else if (ctl.step) begin
			rem_q <= fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
			dq_q  <= {dq_q[QUOT_W-2:0], fits};
		end
	end

	assign quot = dq_q;

endmodule

// ----- sv/proximity_zone_blink_alert.sv -----
// ----------------------------------------------------------------------------
// proximity_zone_blink_alert: distance-driven blink/steady alert level
// Classifies each distance sample into safe, warning or danger and drives
// the shared LED/buzzer level, blinking at a rate that rises as the
// distance closes.
// ----------------------------------------------------------------------------
//  channel  | signals                           | dir | transfer when
//  ---------+-----------------------------------+-----+---------------------------
//  in       | in_valid, distance_tenths, now_ms | in  | in_valid & !in_stall
//  out      | out_valid, alert_on, zone         | out | out_valid & !out_stall
//  cfg      | cfg_we, cfg_index, cfg_data       | in  | cfg_we
//
//  Safe and danger samples go from IDLE straight to FIN. Warning samples
//  pass MUL, BPM and RUN, where the serial elapsed-time subtractor and the
//  bit-serial interval divider step, before reaching FIN.
//  Reset clears state and restores the register defaults; no clearing pass.
//  One sample in flight; a new one is taken while a finished result waits.
//  in_stall stays high until the result moves into the output register,
//  which waits while that register is full and stalled.
// ----------------------------------------------------------------------------
module proximity_zone_blink_alert #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [pzba_pkg::DIST_W-1:0] distance_tenths,
	input  logic [31:0]                    now_ms,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           alert_on,
	output logic [1:0]                     zone,
	// configuration
	input  logic                           cfg_we,
	input  logic [pzba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pzba_pkg::CFG_W-1:0]     cfg_data
);
	import pzba_pkg::*;

	localparam int ND    = (TIME_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int NITER = (ND > QUOT_W) ? ND : QUOT_W;
	localparam int CNT_W = $clog2(NITER);

	// configuration registers
	logic [THR_W-1:0]   alert_thr_q, danger_thr_q;
	logic [BASE_W-1:0]  base_q;
	logic [SLOPE_W-1:0] slope_q;

	// sequencer and item registers
	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	zone_t               zone_item_q;
	logic [THR_W-1:0]    x_q;
	logic [CLOSER_W-1:0] closer_q;
	logic [TIME_WIDTH-1:0] now_q;

	// architectural state
	logic                  level_q;
	logic [TIME_WIDTH-1:0] last_q;

	// output register
	logic        out_valid_q;
	logic        alert_on_q;
	zone_t       zone_out_q;

	// datapath wires
	logic                  in_xfer, out_free, fin_go;
	zone_t                 zone_in;
	logic [TIME_WIDTH-1:0] now_in;
	logic [RECIP_W+THR_W-1:0] prod;
	logic [BPM_W-1:0]      bpm_raw, bpm;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [QUOT_W-1:0]     interval;
	logic                  due;
	ctl_t                  sub_ctl, div_ctl;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && out_free;
	assign now_in   = TIME_WIDTH'(now_ms);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_thr_q  <= THR_W'(1000);
			danger_thr_q <= THR_W'(100);
			base_q       <= BASE_W'(60);
			slope_q      <= SLOPE_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ALERT:  alert_thr_q  <= cfg_data[THR_W-1:0];
				CFG_DANGER: danger_thr_q <= cfg_data[THR_W-1:0];
				CFG_BASE:   base_q       <= cfg_data[BASE_W-1:0];
				CFG_SLOPE:  slope_q      <= cfg_data[SLOPE_W-1:0];
				default:    ;
			endcase
		end
	end

	// zone of the incoming sample: invalid/beyond first, then danger
	always_comb begin
		if (distance_tenths[DIST_W-1]
				|| (distance_tenths[DIST_W-2:0] > (DIST_W-1)'(alert_thr_q))) begin
			zone_in = ZONE_SAFE;
		end else if (distance_tenths[DIST_W-2:0] <= (DIST_W-1)'(danger_thr_q)) begin
			zone_in = ZONE_DANGER;
		end else begin
			zone_in = ZONE_WARN;
		end
	end

	// rate path: closer_cm by reciprocal multiply, then bpm
	assign prod    = (RECIP_W+THR_W)'(x_q) * (RECIP_W+THR_W)'(RECIP_10);
	assign bpm_raw = BPM_W'(base_q) + BPM_W'(slope_q) * BPM_W'(closer_q);
	assign bpm     = (bpm_raw == '0) ? BPM_W'(1) : bpm_raw;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// next state and unit controls
	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		sub_ctl      = '0;
		div_ctl      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				sub_ctl.load = in_valid;
				if (in_valid) begin
					state_d = (zone_in == ZONE_WARN) ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL: state_d = ST_BPM;
			ST_BPM: begin
				div_ctl.load = 1'b1;
				state_d      = ST_RUN;
			end
			ST_RUN: begin
				sub_ctl.step = int'(cnt_q) < ND;
				div_ctl.step = int'(cnt_q) < QUOT_W;
				if (int'(cnt_q) == NITER - 1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// item capture and rate pipeline
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q   <= alert_thr_q - distance_tenths[THR_W-1:0];
			now_q <= now_in;
		end
		if (state_q == ST_MUL) begin
			closer_q <= prod[RECIP_SH +: CLOSER_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_item_q <= ZONE_SAFE;
		end else if (in_xfer) begin
			zone_item_q <= zone_in;
		end
	end

	// serial units
	pzba_serial_sub #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_sub (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sub_ctl),
		.a      (now_in),
		.b      (last_q),
		.diff   (elapsed)
	);

	pzba_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.divisor (bpm),
		.quot    (interval)
	);

	// toggle when elapsed time reaches the interval
	assign due = (|elapsed[TIME_WIDTH-1:QUOT_W]) || (elapsed[QUOT_W-1:0] >= interval);

	// alert state update at result time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			last_q  <= '0;
		end else if (fin_go) begin
			case (zone_item_q)
				ZONE_SAFE:   level_q <= 1'b0;
				ZONE_DANGER: level_q <= 1'b1;
				ZONE_WARN: begin
					if (due) begin
						level_q <= !level_q;
						last_q  <= now_q;
					end
				end
				default: level_q <= 1'b0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			zone_out_q <= zone_item_q;
			case (zone_item_q)
				ZONE_SAFE:   alert_on_q <= 1'b0;
				ZONE_DANGER: alert_on_q <= 1'b1;
				ZONE_WARN:   alert_on_q <= level_q ^ due;
				default:     alert_on_q <= 1'b0;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign alert_on  = alert_on_q;
	assign zone      = zone_out_q;

	// checks
	a_zone_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (zone == ZONE_SAFE || zone == ZONE_WARN || zone == ZONE_DANGER))
		else $error("result zone code out of range");

	a_danger_on: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zone == ZONE_DANGER) |-> alert_on)
		else $error("danger result without alert");

	a_safe_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zone == ZONE_SAFE) |-> !alert_on)
		else $error("safe result with alert on");

	a_toggle_time: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(last_q) |-> (level_q != $past(level_q)))
		else $error("toggle time moved without a level toggle");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (int'(cnt_q) < NITER))
		else $error("serial step count overran");

endmodule
